@@ design/fbc_pkg.sv @@
// Package with the types, S-box rows and round functions of the Feistel cipher.
`default_nettype none

package fbc_pkg;

   localparam int unsigned HALF_W     = 32;
   localparam int unsigned BLOCK_W    = 64;
   localparam int unsigned NUM_KEYS   = 8;
   localparam int unsigned KEY_IDX_W  = 3;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned NUM_ROUNDS = 32;
   localparam int unsigned FWD_ROUNDS = 24;
   localparam int unsigned ROT_AMOUNT = 11;
   localparam int unsigned NIBBLES    = 8;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   typedef logic [NUM_KEYS-1:0][HALF_W-1:0] key_array_type;

   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [HALF_W-1:0] a;
      logic [HALF_W-1:0] b;
   } stage_type;

   typedef logic [NIBBLES-1:0][15:0][3:0] sbox_table_type;

   localparam sbox_table_type SBOX = '{
      '{4'd3, 4'd5, 4'd15, 4'd7, 4'd12, 4'd1, 4'd11, 4'd6,
        4'd14, 4'd0, 4'd8, 4'd13, 4'd2, 4'd9, 4'd10, 4'd4},
      '{4'd9, 4'd5, 4'd7, 4'd0, 4'd1, 4'd8, 4'd3, 4'd2,
        4'd10, 4'd15, 4'd13, 4'd6, 4'd12, 4'd4, 4'd11, 4'd14},
      '{4'd11, 4'd9, 4'd0, 4'd6, 4'd7, 4'd12, 4'd15, 4'd14,
        4'd2, 4'd4, 4'd3, 4'd10, 4'd13, 4'd1, 4'd8, 4'd5},
      '{4'd3, 4'd5, 4'd2, 4'd11, 4'd12, 4'd6, 4'd4, 4'd14,
        4'd15, 4'd9, 4'd8, 4'd0, 4'd1, 4'd10, 4'd13, 4'd7},
      '{4'd2, 4'd11, 4'd3, 4'd0, 4'd14, 4'd9, 4'd10, 4'd4,
        4'd8, 4'd13, 4'd15, 4'd5, 4'd1, 4'd7, 4'd12, 4'd6},
      '{4'd14, 4'd15, 4'd12, 4'd9, 4'd5, 4'd8, 4'd6, 4'd3,
        4'd13, 4'd1, 4'd2, 4'd7, 4'd0, 4'd10, 4'd11, 4'd4},
      '{4'd12, 4'd2, 4'd8, 4'd6, 4'd7, 4'd14, 4'd10, 4'd0,
        4'd9, 4'd5, 4'd15, 4'd3, 4'd1, 4'd4, 4'd11, 4'd13},
      '{4'd12, 4'd8, 4'd11, 4'd6, 4'd14, 4'd3, 4'd2, 4'd9,
        4'd4, 4'd10, 4'd7, 4'd5, 4'd0, 4'd13, 4'd15, 4'd1}
   };

   // Row NIBBLES-1 of the table, the first one written out, works on the top nibble of the word.
   function automatic logic [HALF_W-1:0] mix(input logic [HALF_W-1:0] a,
                                             input logic [HALF_W-1:0] k);
      logic [HALF_W-1:0] x;
      logic [HALF_W-1:0] y;
      x = a + k;
      for (int i = 0; i < NIBBLES; i++) begin
         y[4*(NIBBLES-1-i) +: 4] = SBOX[NIBBLES-1-i][x[4*(NIBBLES-1-i) +: 4]];
      end
      return {y[HALF_W-1-ROT_AMOUNT:0], y[HALF_W-1:HALF_W-ROT_AMOUNT]};
   endfunction

   function automatic logic [KEY_IDX_W-1:0] key_idx(input int unsigned round,
                                                    input op_type op);
      int unsigned idx;
      if (op == OP_ENCRYPT) begin
         idx = (round < FWD_ROUNDS) ? (round % NUM_KEYS) : (NUM_ROUNDS - 1 - round);
      end else begin
         idx = (round < NUM_KEYS) ? round : (NUM_KEYS - 1 - (round % NUM_KEYS));
      end
      return idx[KEY_IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ design/fbc_ifs.sv @@
// Channel interfaces for the request, response and register write ports.
`default_nettype none

interface fbc_req_if;
   import fbc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [BLOCK_W-1:0]   block_in;
   logic                 opcode;
   modport source (output valid, output block_in, output opcode, input ready);
   modport sink   (input valid, input block_in, input opcode, output ready);
endinterface

interface fbc_rsp_if;
   import fbc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [BLOCK_W-1:0]   block_out;
   modport source (output valid, output block_out, input ready);
   modport sink   (input valid, input block_out, output ready);
endinterface

interface fbc_csr_if;
   import fbc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [HALF_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/fbc_round_cell.sv @@
// One Feistel round cell: computes a round and holds its result for the next cell.
`default_nettype none

module fbc_round_cell
   import fbc_pkg::*;
#(
   parameter int unsigned ROUND = 0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stage_type     up,
   output logic               up_ready,
   output stage_type          dn,
   input  wire logic          dn_ready,
   input  wire key_array_type keys
);

   stage_type         stage_ff;
   stage_type         stage_in;
   logic [HALF_W-1:0] key;

   assign up_ready = !stage_ff.valid || dn_ready;
   assign key      = keys[key_idx(ROUND, up.op)];

   always_comb begin
      stage_in       = stage_ff;
      if (up_ready) begin
         stage_in.valid = up.valid;
         stage_in.op    = up.op;
         stage_in.a     = up.b ^ mix(up.a, key);
         stage_in.b     = up.a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.op <= stage_in.op;
      stage_ff.a  <= stage_in.a;
      stage_ff.b  <= stage_in.b;
   end

   assign dn = stage_ff;

endmodule

`default_nettype wire

@@ design/feistel_64bit_block_cipher_ecb_top.sv @@
// Top level of the 32-round Feistel block cipher with its key registers.
// A request passes through the round cells in order, each registering its round, before its response.
// Throughput is one block per cycle while responses are taken; each cell takes a new block whenever it is empty or its
// successor takes its block, so a waiting response stalls only the cells behind it.
// Reset clears all cell valid bits and sets all eight key words to zero.
`default_nettype none

module feistel_64bit_block_cipher_ecb_top
   import fbc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   fbc_req_if.sink    req_ch,
   fbc_rsp_if.source  rsp_ch,
   fbc_csr_if.sink    csr_ch
);

   key_array_type keys_ff;
   stage_type     chain [NUM_ROUNDS+1];
   logic          ready_chain [NUM_ROUNDS+1];

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else if (csr_ch.valid && (csr_ch.index < CSR_IDX_W'(NUM_KEYS))) begin
         keys_ff[csr_ch.index[KEY_IDX_W-1:0]] <= csr_ch.data;
      end
   end

   assign chain[0].valid = req_ch.valid;
   assign chain[0].op    = op_type'(req_ch.opcode);
   assign chain[0].a     = req_ch.block_in[HALF_W-1:0];
   assign chain[0].b     = req_ch.block_in[BLOCK_W-1:HALF_W];
   assign req_ch.ready   = ready_chain[0];

   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      fbc_round_cell #(
         .ROUND(r)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up       (chain[r]),
         .up_ready (ready_chain[r]),
         .dn       (chain[r+1]),
         .dn_ready (ready_chain[r+1]),
         .keys     (keys_ff)
      );
   end

   assign ready_chain[NUM_ROUNDS] = rsp_ch.ready;
   assign rsp_ch.valid            = chain[NUM_ROUNDS].valid;
   assign rsp_ch.block_out        = {chain[NUM_ROUNDS].a, chain[NUM_ROUNDS].b};

   a_empty_out_takes_req: assert property (@(posedge clock) disable iff (reset)
      !chain[NUM_ROUNDS].valid |-> req_ch.ready)
      else $error("request refused while the last cell is empty");

   a_req_enters_cell0: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=>
         (chain[1].valid && (chain[1].op == op_type'($past(req_ch.opcode)))))
      else $error("accepted request missing from the first cell");

   a_stall_holds_last: assert property (@(posedge clock) disable iff (reset)
      (chain[NUM_ROUNDS].valid && !rsp_ch.ready) |=>
         (chain[NUM_ROUNDS].valid && $stable(chain[NUM_ROUNDS].a)
          && $stable(chain[NUM_ROUNDS].b)))
      else $error("last cell changed while its response was stalled");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the 32-round Feistel block cipher in ECB mode.
`default_nettype none

module testbench;
   import fbc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [BLOCK_W-1:0] block;
      op_type             op;
   } block_request_type;

   localparam bit [3:0] SUBST_ROWS [0:7][0:15] = '{
      '{4, 10, 9, 2, 13, 8, 0, 14, 6, 11, 1, 12, 7, 15, 5, 3},
      '{14, 11, 4, 12, 6, 13, 15, 10, 2, 3, 8, 1, 0, 7, 5, 9},
      '{5, 8, 1, 13, 10, 3, 4, 2, 14, 15, 12, 7, 6, 0, 9, 11},
      '{7, 13, 10, 1, 0, 8, 9, 15, 14, 4, 6, 12, 11, 2, 5, 3},
      '{6, 12, 7, 1, 5, 15, 13, 8, 4, 10, 9, 14, 0, 3, 11, 2},
      '{4, 11, 10, 0, 7, 2, 1, 13, 3, 6, 8, 5, 9, 12, 15, 14},
      '{13, 11, 4, 1, 3, 15, 5, 9, 0, 10, 14, 7, 6, 8, 2, 12},
      '{1, 15, 13, 0, 5, 7, 10, 4, 9, 2, 3, 14, 6, 11, 8, 12}
   };

   logic clock;
   logic reset;

   fbc_req_if req_ch();
   fbc_rsp_if rsp_ch();
   fbc_csr_if csr_ch();

   feistel_64bit_block_cipher_ecb_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   logic [HALF_W-1:0]  key_words [NUM_KEYS];
   block_request_type  pending_requests [$];
   logic [BLOCK_W-1:0] expected_blocks [$];
   logic [BLOCK_W-1:0] oldest_block;
   bit                 sender_idles;
   bit                 receiver_stalls;
   int                 req_gap;
   int                 rsp_stall;
   int                 mismatches;
   int                 encrypt_count;
   int                 decrypt_count;
   int                 checked_count;
   int                 csr_writes;
   int                 key_settings;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [HALF_W-1:0] round_mix(input logic [HALF_W-1:0] half,
                                                   input logic [HALF_W-1:0] key);
      logic [HALF_W-1:0] sum;
      logic [HALF_W-1:0] subst;
      sum = half + key;
      for (int row = 0; row < 8; row++) begin
         subst[4*(7-row) +: 4] = SUBST_ROWS[row][sum[4*(7-row) +: 4]];
      end
      return (subst << 11) | (subst >> 21);
   endfunction

   function automatic logic [2:0] key_slot(input int unsigned round, input op_type op);
      logic [2:0] low_bits;
      low_bits = round[2:0];
      if (op == OP_ENCRYPT) begin
         return (round < 24) ? low_bits : ~low_bits;
      end
      return (round < 8) ? low_bits : ~low_bits;
   endfunction

   function automatic logic [BLOCK_W-1:0] cipher_block(input logic [BLOCK_W-1:0] block,
                                                       input op_type op);
      logic [HALF_W-1:0] left;
      logic [HALF_W-1:0] right;
      logic [HALF_W-1:0] next_left;
      left  = block[31:0];
      right = block[63:32];
      for (int unsigned round = 0; round < 32; round++) begin
         next_left = right ^ round_mix(left, key_words[key_slot(round, op)]);
         right     = left;
         left      = next_left;
      end
      return {left, right};
   endfunction

   function automatic int pick_gap(input bit enabled);
      int roll;
      if (!enabled) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [HALF_W-1:0] pick_half();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic queue_block(input logic [BLOCK_W-1:0] block, input op_type op);
      block_request_type item;
      item.block = block;
      item.op    = op;
      pending_requests = {pending_requests, item};
   endtask

   task automatic drain_blocks();
      while (pending_requests.size() != 0 || req_ch.valid || expected_blocks.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index, input logic [HALF_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ch.ready);
   endtask

   task automatic csr_finish();
      csr_ch.valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      key_settings++;
   endtask

   task automatic queue_random_batch(input int count);
      logic [BLOCK_W-1:0] plain;
      int                 added;
      int                 roll;
      added = 0;
      while (added < count) begin
         roll  = $urandom_range(0, 99);
         plain = {$urandom, $urandom};
         if (roll < 35) begin
            queue_block(plain, OP_ENCRYPT);
            queue_block(cipher_block(plain, OP_ENCRYPT), OP_DECRYPT);
            added += 2;
         end else if (roll < 50) begin
            queue_block(plain, OP_DECRYPT);
            queue_block(cipher_block(plain, OP_DECRYPT), OP_ENCRYPT);
            added += 2;
         end else if (roll < 60) begin
            queue_block({pick_half(), pick_half()}, op_type'($urandom_range(0, 1)));
            added++;
         end else begin
            queue_block(plain, op_type'($urandom_range(0, 1)));
            added++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid    <= 1'b0;
         req_ch.block_in <= '0;
         req_ch.opcode   <= OP_ENCRYPT;
         req_gap = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_gap = req_gap - 1;
         end else if (pending_requests.size() != 0) begin
            req_ch.valid    <= 1'b1;
            req_ch.block_in <= pending_requests[0].block;
            req_ch.opcode   <= pending_requests[0].op;
            void'(pending_requests.pop_front());
            req_gap = pick_gap(sender_idles);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_stall = pick_gap(receiver_stalls);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            csr_writes++;
            if (csr_ch.index < NUM_KEYS) begin
               key_words[csr_ch.index[KEY_IDX_W-1:0]] = csr_ch.data;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_blocks = {expected_blocks,
                               cipher_block(req_ch.block_in, op_type'(req_ch.opcode))};
            if (req_ch.opcode == OP_ENCRYPT) begin
               encrypt_count++;
            end else begin
               decrypt_count++;
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch($sformatf("block_out %h arrived with nothing expected",
                                         rsp_ch.block_out));
            end else begin
               oldest_block = expected_blocks.pop_front();
               checked_count++;
               if (rsp_ch.block_out !== oldest_block) begin
                  report_mismatch($sformatf("block_out got %h expected %h",
                                            rsp_ch.block_out, oldest_block));
               end
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [BLOCK_W-1:0] plain;
      logic [HALF_W-1:0]  word;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= '0;
      csr_ch.data     <= '0;
      reset           <= 1'b1;
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      mismatches      = 0;
      encrypt_count   = 0;
      decrypt_count   = 0;
      checked_count   = 0;
      csr_writes      = 0;
      key_settings    = 1;
      for (int i = 0; i < NUM_KEYS; i++) begin
         key_words[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The key file comes out of reset as all zeros.
      queue_block('0, OP_ENCRYPT);
      queue_block('0, OP_DECRYPT);
      queue_block('1, OP_ENCRYPT);
      queue_block('1, OP_DECRYPT);
      queue_block(64'h00000000_FFFFFFFF, OP_ENCRYPT);
      queue_block(64'hFFFFFFFF_00000000, OP_DECRYPT);
      drain_blocks();

      // Writes past the last key word must leave the key file alone.
      for (int i = 0; i < 16; i++) begin
         csr_write(CSR_IDX_W'(i), (i < NUM_KEYS) ? 32'hFFFF_FFFF : 32'h0000_0000);
      end
      csr_finish();
      queue_block('0, OP_ENCRYPT);
      queue_block('0, OP_DECRYPT);
      queue_block('1, OP_ENCRYPT);
      queue_block('1, OP_DECRYPT);
      queue_block(64'h80000000_00000001, OP_ENCRYPT);
      queue_block(64'h00000001_80000000, OP_DECRYPT);
      drain_blocks();

      for (int i = 0; i < NUM_KEYS; i++) begin
         csr_write(CSR_IDX_W'(i), 32'h0123_4567 + i * 32'h1111_1111);
      end
      for (int i = NUM_KEYS; i < 16; i++) begin
         csr_write(CSR_IDX_W'(i), 32'hFFFF_FFFF);
      end
      csr_finish();
      plain = 64'h0123456789ABCDEF;
      queue_block(plain, OP_ENCRYPT);
      queue_block(cipher_block(plain, OP_ENCRYPT), OP_DECRYPT);
      queue_block(64'h55555555_55555555, OP_ENCRYPT);
      queue_block(64'h55555555_55555555, OP_DECRYPT);
      queue_block(64'hAAAAAAAA_AAAAAAAA, OP_ENCRYPT);
      queue_block(64'hAAAAAAAA_AAAAAAAA, OP_DECRYPT);
      queue_block(64'hFEDCBA98_76543210, OP_DECRYPT);
      queue_block(64'hFFFFFFFF_FFFFFFFE, OP_ENCRYPT);
      drain_blocks();

      for (int phase = 0; phase < 6; phase++) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            case (phase)
               0: word = i[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
               1: word = i[0] ? 32'h0000_0000 : 32'hFFFF_FFFF;
               default: word = ($urandom_range(0, 7) == 0) ? pick_half() : $urandom;
            endcase
            csr_write(CSR_IDX_W'(i), word);
         end
         repeat ($urandom_range(1, 3)) begin
            csr_write(CSR_IDX_W'($urandom_range(NUM_KEYS, 15)), $urandom);
         end
         csr_finish();
         for (int batch = 0; batch < 2; batch++) begin
            sender_idles    = (phase != 2) && ($urandom_range(0, 3) != 0);
            receiver_stalls = (phase != 2) && ($urandom_range(0, 3) != 0);
            queue_random_batch(52);
            drain_blocks();
         end
      end

      repeat (40) @(posedge clock);
      if (expected_blocks.size() != 0) begin
         report_mismatch($sformatf("%0d expected blocks never arrived", expected_blocks.size()));
      end
      $display("Checked %0d blocks, %0d encrypt and %0d decrypt, under %0d key settings.",
               checked_count, encrypt_count, decrypt_count, key_settings);
      $display("The key file took %0d register writes, some aimed past the last key word.",
               csr_writes);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
design/fbc_pkg.sv
design/fbc_ifs.sv
design/fbc_round_cell.sv
design/feistel_64bit_block_cipher_ecb_top.sv
dv/testbench.sv
